/* rtl/core/gate_motion_supervisor_assert.svh */
// assertion macros used by gms_back of the gate motion supervisor
// expects clk_i and rst_ni in the scope of each use
`ifndef GATE_MOTION_SUPERVISOR_ASSERT_SVH
`define GATE_MOTION_SUPERVISOR_ASSERT_SVH
`ifndef SYNTHESIS
`define GMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define GMS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define GMS_ASSERT(lbl, prop, msg)
`define GMS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* rtl/core/gms_pkg.sv */
// types and constants of the gate motion supervisor
// used by gms_front, gms_fifo, gms_back and the top level
package gms_pkg;

  localparam int unsigned TimeW  = 24;
  localparam int unsigned PulseW = 16;
  localparam int unsigned CfgW   = 24;

  localparam logic [TimeW-1:0]  TimeMax          = {TimeW{1'b1}};
  localparam logic [TimeW-1:0]  OpenTimeoutRst   = 24'd15000;
  localparam logic [TimeW-1:0]  CloseTimeoutRst  = 24'd15000;
  localparam logic [TimeW-1:0]  AutoCloseRst     = 24'd180000;
  localparam logic [PulseW-1:0] RelayPulseRst    = 16'd1000;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_OPEN  = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_SPARE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CLS_TICK  = 2'd0,
    CLS_OPEN  = 2'd1,
    CLS_CLOSE = 2'd2
  } cls_e;

  typedef enum logic [1:0] {
    POS_CLOSED  = 2'd0,
    POS_OPEN    = 2'd1,
    POS_UNKNOWN = 2'd2
  } pos_e;

  typedef enum logic [2:0] {
    OP_IDLE    = 3'b001,
    OP_OPENING = 3'b010,
    OP_CLOSING = 3'b100
  } op_e;

  typedef enum logic [2:0] {
    ST_CLOSED  = 3'd0,
    ST_OPEN    = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_OPENING = 3'd3,
    ST_CLOSING = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_OPEN_TIMEOUT  = 2'd0,
    CFG_CLOSE_TIMEOUT = 2'd1,
    CFG_AUTO_CLOSE    = 2'd2,
    CFG_RELAY_PULSE   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    cls_e cls;
    pos_e pos;
  } item_t;

  // first field in the highest bits
  typedef struct packed {
    logic [TimeW-1:0] autoclose_left;
    logic [TimeW-1:0] timeout_left;
    logic [TimeW-1:0] op_ticks;
    logic             auto_close_fired;
    logic             auto_close_armed;
    logic             alert_raised;
    logic             alert_on;
    logic             relay_drive;
    status_e          gate_status;
  } result_t;

endpackage

/* rtl/core/gate_motion_supervisor.sv */
// gate motion supervisor: one result word per input word, one per cycle unless stalled
// an input word passes the decode register, the queue and the result register in that
// order; its result word is valid once the result register has taken it
// the back stage settles a whole step (timers, compares, remaining counts) combinationally
// the 2-entry queue lets front and back stall independently
// asynchronous active-low reset: idle, position unknown, config registers at defaults
module gate_motion_supervisor import gms_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [7:0]      s_axis_tdata,   // closed_sensor_active, open_sensor_active, zero pad
  input  logic [1:0]      s_axis_tuser,   // kind
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // gate_status, relay_drive, alert_on, alert_raised, auto_close_armed,
  // auto_close_fired, op_ticks, timeout_left, autoclose_left
  output logic [79:0]     m_axis_tdata,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  logic    f_valid, f_ready, b_valid, b_ready;
  item_t   f_item, b_item;
  result_t out_word;

  gms_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_valid_o  (f_valid),
    .push_ready_i  (f_ready),
    .push_item_o   (f_item)
  );

  gms_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_item_o   (b_item)
  );

  gms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pop_valid_i (b_valid),
    .pop_ready_o (b_ready),
    .pop_item_i  (b_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_word_o  (out_word)
  );

  assign m_axis_tdata = out_word;

endmodule

/* rtl/core/gms_front.sv */
// front stage: accepts input words, decodes kind and end-sensor position
// depends on gms_pkg
module gms_front import gms_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // closed_sensor_active, open_sensor_active, zero pad
  input  logic [1:0] s_axis_tuser,   // kind
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output item_t      push_item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  sc, so;

  assign sc = s_axis_tdata[0];
  assign so = s_axis_tdata[1];

  assign s_axis_tready = !valid_q || push_ready_i;

  always_comb begin
    item_d = item_q;
    valid_d = valid_q;
    if (s_axis_tready) begin
      valid_d = s_axis_tvalid;
      unique case (kind_e'(s_axis_tuser))
        KIND_OPEN:  item_d.cls = CLS_OPEN;
        KIND_CLOSE: item_d.cls = CLS_CLOSE;
        default:    item_d.cls = CLS_TICK;
      endcase
      if (sc && !so) begin
        item_d.pos = POS_CLOSED;
      end else if (!sc && so) begin
        item_d.pos = POS_OPEN;
      end else begin
        item_d.pos = POS_UNKNOWN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

endmodule

/* rtl/core/gms_fifo.sv */
// short queue of decoded words between front and back
// depends on gms_pkg
module gms_fifo import gms_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = cnt_q != CntW'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_item_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

/* rtl/core/gms_back.sv */
// back stage: supervisor state, timers, config registers and result register
// depends on gms_pkg and gate_motion_supervisor_assert.svh
`include "gate_motion_supervisor_assert.svh"
module gms_back import gms_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  item_t           pop_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output result_t         out_word_o
);

  logic [TimeW-1:0]  open_to_q, close_to_q, auto_dly_q;
  logic [PulseW-1:0] pulse_len_q;

  pos_e              last_q, last_d;
  op_e               op_q, op_d;
  logic [TimeW-1:0]  oe_q, oe_d, ope_q, ope_d;
  logic              alert_q, alert_d, armed_q, armed_d;
  logic [PulseW-1:0] pulse_q, pulse_d;

  logic              ov_q, ov_d;
  result_t           out_q, res;
  logic              step, raised, fired;
  logic [TimeW-1:0]  lim_a, lim_b;

  assign pop_ready_o = !ov_q || out_ready_i;
  assign step = pop_valid_i && pop_ready_o;

  always_comb begin
    last_d  = last_q;
    op_d    = op_q;
    oe_d    = oe_q;
    ope_d   = ope_q;
    alert_d = alert_q;
    armed_d = armed_q;
    pulse_d = pulse_q;
    raised  = 1'b0;
    fired   = 1'b0;
    lim_a   = '0;
    lim_b   = '0;
    res     = '0;

    // time advance or request
    unique case (pop_item_i.cls)
      CLS_OPEN: begin
        if (pop_item_i.pos != POS_OPEN) begin
          op_d    = OP_OPENING;
          oe_d    = '0;
          alert_d = 1'b0;
          pulse_d = pulse_len_q;
        end
      end
      CLS_CLOSE: begin
        if (pop_item_i.pos != POS_CLOSED) begin
          op_d    = OP_CLOSING;
          oe_d    = '0;
          alert_d = 1'b0;
          pulse_d = pulse_len_q;
        end
      end
      default: begin
        if (pulse_q != '0) begin
          pulse_d = pulse_q - 1'b1;
        end
        if (op_q != OP_IDLE && oe_q != TimeMax) begin
          oe_d = oe_q + 1'b1;
        end
        if (armed_q && ope_q != TimeMax) begin
          ope_d = ope_q + 1'b1;
        end
      end
    endcase

    // position change and completion
    if (pop_item_i.pos != last_q) begin
      if (pop_item_i.pos == POS_CLOSED) begin
        armed_d = 1'b0;
      end else if (pop_item_i.pos == POS_OPEN) begin
        armed_d = 1'b1;
        ope_d   = '0;
      end
      last_d = pop_item_i.pos;
      if ((op_d == OP_OPENING && pop_item_i.pos == POS_OPEN) ||
          (op_d == OP_CLOSING && pop_item_i.pos == POS_CLOSED)) begin
        op_d    = OP_IDLE;
        alert_d = 1'b0;
      end
    end

    // timeout check
    if (op_d != OP_IDLE) begin
      lim_a = (op_d == OP_OPENING) ? open_to_q : close_to_q;
      if (oe_d >= lim_a && !alert_d) begin
        alert_d = 1'b1;
        raised  = 1'b1;
      end
    end

    // auto-close
    if (armed_d && pop_item_i.pos == POS_OPEN && op_d == OP_IDLE && ope_d >= auto_dly_q) begin
      op_d    = OP_CLOSING;
      oe_d    = '0;
      alert_d = 1'b0;
      pulse_d = pulse_len_q;
      armed_d = 1'b0;
      fired   = 1'b1;
    end

    // status word
    unique case (op_d)
      OP_OPENING: res.gate_status = ST_OPENING;
      OP_CLOSING: res.gate_status = ST_CLOSING;
      default: begin
        unique case (pop_item_i.pos)
          POS_CLOSED: res.gate_status = ST_CLOSED;
          POS_OPEN:   res.gate_status = ST_OPEN;
          default:    res.gate_status = ST_UNKNOWN;
        endcase
      end
    endcase
    if (op_d != OP_IDLE) begin
      lim_b = (op_d == OP_OPENING) ? open_to_q : close_to_q;
      res.op_ticks     = oe_d;
      res.timeout_left = (lim_b > oe_d) ? lim_b - oe_d : '0;
    end
    if (armed_d && pop_item_i.pos == POS_OPEN && op_d == OP_IDLE) begin
      res.autoclose_left = (auto_dly_q > ope_d) ? auto_dly_q - ope_d : '0;
    end
    res.relay_drive      = pulse_d != '0;
    res.alert_on         = alert_d;
    res.alert_raised     = raised;
    res.auto_close_armed = armed_d;
    res.auto_close_fired = fired;
  end

  always_comb begin
    ov_d = ov_q;
    if (pop_ready_o) begin
      ov_d = pop_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_to_q   <= OpenTimeoutRst;
      close_to_q  <= CloseTimeoutRst;
      auto_dly_q  <= AutoCloseRst;
      pulse_len_q <= RelayPulseRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_OPEN_TIMEOUT:  open_to_q   <= cfg_data_i;
        CFG_CLOSE_TIMEOUT: close_to_q  <= cfg_data_i;
        CFG_AUTO_CLOSE:    auto_dly_q  <= cfg_data_i;
        CFG_RELAY_PULSE:   pulse_len_q <= cfg_data_i[PulseW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= POS_UNKNOWN;
      op_q    <= OP_IDLE;
      oe_q    <= '0;
      ope_q   <= '0;
      alert_q <= 1'b0;
      armed_q <= 1'b0;
      pulse_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      ov_q <= ov_d;
      if (step) begin
        last_q  <= last_d;
        op_q    <= op_d;
        oe_q    <= oe_d;
        ope_q   <= ope_d;
        alert_q <= alert_d;
        armed_q <= armed_d;
        pulse_q <= pulse_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = ov_q;
  assign out_word_o  = out_q;

  `GMS_ASSERT(a_fire_starts_close, ov_q && out_q.auto_close_fired |-> out_q.gate_status == ST_CLOSING && !out_q.auto_close_armed && out_q.op_ticks == '0, "auto-close word without a fresh closing")
  `GMS_ASSERT(a_raise_in_op, ov_q && out_q.alert_raised |-> out_q.alert_on && (out_q.gate_status == ST_OPENING || out_q.gate_status == ST_CLOSING), "alert raised outside an operation")
  `GMS_ASSERT(a_stall_holds_state, ov_q && !out_ready_i |=> $stable(op_q) && $stable(oe_q) && $stable(pulse_q), "state moved while result word stalled")
  `GMS_ASSERT(a_idle_zero_time, ov_q && out_q.gate_status != ST_OPENING && out_q.gate_status != ST_CLOSING |-> out_q.op_ticks == '0 && out_q.timeout_left == '0, "idle word with operation time")
  `GMS_ASSERT_RST(a_reset_empty, !rst_ni |=> !ov_q && op_q == OP_IDLE, "result register or operation not cleared in reset")

endmodule

/* tb/testbench.sv */
// self-checking testbench for gate_motion_supervisor: streams sensor/request words,
// predicts every status word in a tracker class and compares it field by field
// depends on gms_pkg and the gate_motion_supervisor rtl
module testbench import gms_pkg::*; ();

  class gate_tracker;
    logic [TimeW-1:0]  open_limit;
    logic [TimeW-1:0]  close_limit;
    logic [TimeW-1:0]  auto_delay;
    logic [PulseW-1:0] pulse_len;
    pos_e              last_pos;
    op_e               op;
    logic [TimeW-1:0]  op_elapsed;
    logic [TimeW-1:0]  open_elapsed;
    logic [PulseW-1:0] pulse_left;
    logic              alert;
    logic              armed;
    result_t           expected_status[$];
    int                mismatches;

    function new();
      open_limit   = OpenTimeoutRst;
      close_limit  = CloseTimeoutRst;
      auto_delay   = AutoCloseRst;
      pulse_len    = RelayPulseRst;
      last_pos     = POS_UNKNOWN;
      op           = OP_IDLE;
      op_elapsed   = '0;
      open_elapsed = '0;
      pulse_left   = '0;
      alert        = 1'b0;
      armed        = 1'b0;
      mismatches   = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgW-1:0] value);
      case (idx)
        CFG_OPEN_TIMEOUT:  open_limit = value;
        CFG_CLOSE_TIMEOUT: close_limit = value;
        CFG_AUTO_CLOSE:    auto_delay = value;
        CFG_RELAY_PULSE:   pulse_len = value[PulseW-1:0];
        default: ;
      endcase
    endfunction

    function void start_op(op_e next_op);
      op         = next_op;
      op_elapsed = '0;
      alert      = 1'b0;
      pulse_left = pulse_len;
    endfunction

    function void note_word(kind_e kind, logic sc, logic so);
      pos_e             pos;
      result_t          r;
      logic [TimeW-1:0] lim;
      logic             raised;
      logic             fired;
      raised = 1'b0;
      fired  = 1'b0;
      r      = '0;
      if (sc && !so) pos = POS_CLOSED;
      else if (!sc && so) pos = POS_OPEN;
      else pos = POS_UNKNOWN;

      case (kind)
        KIND_OPEN: if (pos != POS_OPEN) start_op(OP_OPENING);
        KIND_CLOSE: if (pos != POS_CLOSED) start_op(OP_CLOSING);
        default: begin
          if (pulse_left != '0) pulse_left--;
          if (op != OP_IDLE && op_elapsed != TimeMax) op_elapsed++;
          if (armed && open_elapsed != TimeMax) open_elapsed++;
        end
      endcase

      if (pos != last_pos) begin
        if (pos == POS_CLOSED) begin
          armed = 1'b0;
        end else if (pos == POS_OPEN) begin
          armed        = 1'b1;
          open_elapsed = '0;
        end
        last_pos = pos;
        if ((op == OP_OPENING && pos == POS_OPEN) || (op == OP_CLOSING && pos == POS_CLOSED)) begin
          op    = OP_IDLE;
          alert = 1'b0;
        end
      end

      lim = (op == OP_OPENING) ? open_limit : close_limit;
      if (op != OP_IDLE && op_elapsed >= lim && !alert) begin
        alert  = 1'b1;
        raised = 1'b1;
      end

      if (armed && pos == POS_OPEN && op == OP_IDLE && open_elapsed >= auto_delay) begin
        start_op(OP_CLOSING);
        armed = 1'b0;
        fired = 1'b1;
      end

      lim = (op == OP_OPENING) ? open_limit : close_limit;
      case (op)
        OP_OPENING: r.gate_status = ST_OPENING;
        OP_CLOSING: r.gate_status = ST_CLOSING;
        default: begin
          case (pos)
            POS_CLOSED: r.gate_status = ST_CLOSED;
            POS_OPEN:   r.gate_status = ST_OPEN;
            default:    r.gate_status = ST_UNKNOWN;
          endcase
        end
      endcase
      if (op != OP_IDLE) begin
        r.op_ticks     = op_elapsed;
        r.timeout_left = (lim > op_elapsed) ? lim - op_elapsed : '0;
      end
      if (armed && pos == POS_OPEN && op == OP_IDLE)
        r.autoclose_left = (auto_delay > open_elapsed) ? auto_delay - open_elapsed : '0;
      r.relay_drive      = (pulse_left != '0);
      r.alert_on         = alert;
      r.alert_raised     = raised;
      r.auto_close_armed = armed;
      r.auto_close_fired = fired;
      expected_status.push_back(r);
    endfunction

    function void compare_field(string name, logic [TimeW-1:0] want, logic [TimeW-1:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (expected_status.size() == 0) begin
        $display("%0t: status word with none expected, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_status.pop_front();
      compare_field("gate_status", TimeW'(want.gate_status), TimeW'(got.gate_status));
      compare_field("relay_drive", TimeW'(want.relay_drive), TimeW'(got.relay_drive));
      compare_field("alert_on", TimeW'(want.alert_on), TimeW'(got.alert_on));
      compare_field("alert_raised", TimeW'(want.alert_raised), TimeW'(got.alert_raised));
      compare_field("auto_close_armed", TimeW'(want.auto_close_armed),
                    TimeW'(got.auto_close_armed));
      compare_field("auto_close_fired", TimeW'(want.auto_close_fired),
                    TimeW'(got.auto_close_fired));
      compare_field("op_ticks", want.op_ticks, got.op_ticks);
      compare_field("timeout_left", want.timeout_left, got.timeout_left);
      compare_field("autoclose_left", want.autoclose_left, got.autoclose_left);
    endfunction
  endclass

  localparam int unsigned StallLimit = 4000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [7:0]      s_axis_tdata = '0;   // closed_sensor_active, open_sensor_active, zero pad
  logic [1:0]      s_axis_tuser = '0;   // kind
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  // gate_status, relay_drive, alert_on, alert_raised, auto_close_armed,
  // auto_close_fired, op_ticks, timeout_left, autoclose_left
  logic [79:0]     m_axis_tdata;
  logic            cfg_we_i = 1'b0;
  logic [1:0]      cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  gate_tracker tracker = new();
  int          send_idle = 35;
  int          recv_idle = 64;
  int          stall_cycles = 0;
  pos_e        place = POS_CLOSED;
  logic        heading_up = 1'b0;

  gate_motion_supervisor DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      tracker.note_word(kind_e'(s_axis_tuser), s_axis_tdata[0], s_axis_tdata[1]);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tracker.check_word(result_t'(m_axis_tdata));
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_word(input kind_e k, input logic sc, input logic so);
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= {6'b0, so, sc};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (tracker.expected_status.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    tracker.set_reg(idx, value);
  endtask

  task automatic configure(input logic [CfgW-1:0] open_t, input logic [CfgW-1:0] close_t,
                           input logic [CfgW-1:0] auto_t, input logic [PulseW-1:0] pulse_t);
    repeat (6) @(posedge clk_i);
    write_reg(CFG_OPEN_TIMEOUT, open_t);
    write_reg(CFG_CLOSE_TIMEOUT, close_t);
    write_reg(CFG_AUTO_CLOSE, auto_t);
    write_reg(CFG_RELAY_PULSE, {{(CfgW-PulseW){1'b0}}, pulse_t});
    cfg_we_i <= 1'b0;
  endtask

  // mostly a plausible gate travelling between its end sensors, some noise words
  task automatic send_random_words(input int count);
    int    pause_at;
    int    r;
    kind_e k;
    logic  sc;
    logic  so;
    pause_at = $urandom_range(count / 4, 3 * count / 4);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) wait_for_results();
      if ($urandom_range(0, 99) < 20) begin
        send_word(kind_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          k = KIND_OPEN;
          heading_up = 1'b1;
        end else if (r < 16) begin
          k = KIND_CLOSE;
          heading_up = 1'b0;
        end else begin
          k = KIND_TICK;
          if ($urandom_range(0, 29) == 0) heading_up = !heading_up;
          if ($urandom_range(0, 3) == 0) begin
            if (heading_up) place = (place == POS_CLOSED) ? POS_UNKNOWN : POS_OPEN;
            else place = (place == POS_OPEN) ? POS_UNKNOWN : POS_CLOSED;
          end
        end
        sc = (place == POS_CLOSED);
        so = (place == POS_OPEN);
        // sensor glitch, both ends seen at once
        if ($urandom_range(0, 24) == 0) begin
          sc = 1'b1;
          so = 1'b1;
        end
        send_word(k, sc, so);
      end
    end
    wait_for_results();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_random_words(120);

    configure(24'd2, 24'd0, 24'd0, 16'd3);
    send_word(KIND_TICK, 1'b0, 1'b0);
    send_word(KIND_TICK, 1'b1, 1'b1);
    send_word(KIND_TICK, 1'b1, 1'b0);
    send_word(KIND_CLOSE, 1'b1, 1'b0);
    send_word(KIND_OPEN, 1'b1, 1'b0);
    send_word(KIND_OPEN, 1'b1, 1'b0);
    send_word(KIND_TICK, 1'b1, 1'b0);
    send_word(KIND_TICK, 1'b0, 1'b0);
    send_word(KIND_TICK, 1'b0, 1'b0);
    send_word(KIND_TICK, 1'b0, 1'b0);
    send_word(KIND_CLOSE, 1'b0, 1'b0);
    send_word(KIND_SPARE, 1'b0, 1'b0);
    send_word(KIND_TICK, 1'b1, 1'b0);
    send_word(KIND_OPEN, 1'b1, 1'b0);
    send_word(KIND_TICK, 1'b0, 1'b1);
    send_word(KIND_OPEN, 1'b0, 1'b1);
    send_word(KIND_TICK, 1'b1, 1'b1);
    send_word(KIND_TICK, 1'b1, 1'b0);
    send_random_words(150);

    send_idle = 64;
    recv_idle = 35;
    configure(TimeMax, TimeMax, TimeMax, 16'hFFFF);
    send_random_words(150);
    configure(24'd1, 24'd1, 24'd1, 16'd1);
    send_random_words(150);

    send_idle = 0;
    recv_idle = 0;
    configure(CfgW'($urandom_range(0, 30)), CfgW'($urandom_range(0, 30)),
              CfgW'($urandom_range(0, 40)), PulseW'($urandom_range(0, 8)));
    send_random_words(180);
    configure(CfgW'($urandom_range(0, 30)), CfgW'($urandom_range(0, 30)),
              CfgW'($urandom_range(0, 40)), PulseW'($urandom_range(0, 8)));
    send_random_words(180);
    configure(CfgW'($urandom()), CfgW'($urandom()), CfgW'($urandom()),
              PulseW'($urandom_range(0, 65535)));
    send_random_words(170);

    repeat (20) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.expected_status.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
